>>> hw/rtl/vias_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vias_pkg;

    // item kinds
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_WINDOW = 1'b1;

    // debounced button codes
    localparam logic [2:0] BTN_NONE       = 3'd0;
    localparam logic [2:0] BTN_RIGHT      = 3'd1;
    localparam logic [2:0] BTN_CENTER     = 3'd2;
    localparam logic [2:0] BTN_LEFT       = 3'd4;
    localparam logic [2:0] BTN_LEFT_RIGHT = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_INPUT_COUNT    = 2'd0;
    localparam logic [1:0] CFG_SYNC_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_LOST_LIMIT     = 2'd2;

    localparam logic [4:0] INPUT_COUNT_RST    = 5'd8;
    localparam logic [7:0] SYNC_THRESHOLD_RST = 8'd240;
    localparam logic [7:0] LOST_LIMIT_RST     = 8'd120;

    typedef struct packed {
        logic [4:0] choice;
        logic       lost;
        logic [7:0] lost_windows;
        logic       active;
        logic       auto_mode;
        logic       step_down;
        logic       leds_on;
        logic       ready;
        logic [2:0] held;
    } sel_state_t;

    // one-hot mask of an input: byte n>>3, bit order 3,2,1,0,4,5,6,7 within it
    function automatic logic [31:0] mask_of(input logic [4:0] n);
        logic [7:0] b;
        case (n[2:0])
            3'd0:    b = 8'h08;
            3'd1:    b = 8'h04;
            3'd2:    b = 8'h02;
            3'd3:    b = 8'h01;
            3'd4:    b = 8'h10;
            3'd5:    b = 8'h20;
            3'd6:    b = 8'h40;
            default: b = 8'h80;
        endcase
        return {24'd0, b} << {n[4:3], 3'b000};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vias_window.sv
`timescale 1ns / 1ps
`default_nettype none

module vias_window
    import vias_pkg::*;
#(
    parameter int MAX_INPUTS = 24
) (
    input  wire sel_state_t st_i,
    input  wire logic [2:0] buttons_i,
    input  wire logic [7:0] sync_count_i,
    input  wire logic [4:0] input_count_i,
    input  wire logic [7:0] sync_threshold_i,
    input  wire logic [7:0] lost_limit_i,
    output sel_state_t      st_o
);

    localparam logic [5:0] MAX_N = 6'(MAX_INPUTS);

    logic [5:0] count_ext;
    logic [5:0] n_inputs;

    function automatic sel_state_t judge(input sel_state_t s, input logic [7:0] cnt,
                                         input logic [7:0] thr, input logic [7:0] limit);
        sel_state_t r;
        r = s;
        if (cnt < thr && r.auto_mode) begin
            if (r.active) begin
                r.active       = 1'b0;
                r.lost_windows = 8'd1;
            end else if (r.lost_windows != 8'd0) begin
                r.lost_windows = r.lost_windows + 8'd1;
            end
            if (r.lost_windows >= limit) begin
                r.lost         = 1'b1;
                r.lost_windows = 8'd0;
            end
        end else begin
            r.lost         = 1'b0;
            r.lost_windows = 8'd0;
            r.active       = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [4:0] step_next(input logic [4:0] cur, input logic down,
                                             input logic [5:0] n);
        logic [5:0] up;
        logic [5:0] dn;
        logic [5:0] last;
        logic [4:0] r;
        up   = {1'b0, cur} + 6'd1;
        dn   = {1'b0, cur} - 6'd1;
        last = n - 6'd1;
        if (!down) begin
            r = (up >= n) ? 5'd0 : up[4:0];
        end else if (cur == 5'd0) begin
            r = last[4:0];
        end else begin
            r = (dn >= n) ? 5'd0 : dn[4:0];
        end
        return r;
    endfunction

    always_comb begin
        count_ext = {1'b0, input_count_i};
        if (count_ext == 6'd0) begin
            n_inputs = 6'd1;
        end else if (count_ext > MAX_N) begin
            n_inputs = MAX_N;
        end else begin
            n_inputs = count_ext;
        end
    end

    always_comb begin
        sel_state_t s;
        logic       force_step;
        s          = judge(st_i, sync_count_i, sync_threshold_i, lost_limit_i);
        force_step = 1'b0;
        if (s.lost) begin
            s.active = 1'b0;
            s.choice = step_next(s.choice, s.step_down, n_inputs);
            s.ready  = 1'b0;
        end
        if (buttons_i == BTN_NONE) begin
            s.held = BTN_NONE;
        end else if (buttons_i != s.held) begin
            s.held = buttons_i;
            case (buttons_i)
                BTN_CENTER: begin
                    s.auto_mode = !s.auto_mode;
                    s.lost      = 1'b1;
                end
                BTN_LEFT: begin
                    s.step_down = 1'b0;
                    force_step  = 1'b1;
                end
                BTN_RIGHT: begin
                    s.step_down = 1'b1;
                    force_step  = 1'b1;
                end
                BTN_LEFT_RIGHT: begin
                    s.leds_on = !s.leds_on;
                end
                default: begin
                end
            endcase
        end
        // forced step: judge once more, then drop and step regardless
        if (force_step) begin
            s        = judge(s, sync_count_i, sync_threshold_i, lost_limit_i);
            s.active = 1'b0;
            s.lost   = 1'b1;
            s.choice = step_next(s.choice, s.step_down, n_inputs);
            s.ready  = 1'b0;
        end
        st_o = s;
    end

endmodule

`default_nettype wire

>>> hw/rtl/video_input_autoselect_core.sv
// Input selector of a video switch.
// s_ channel: one word per event. s_func 0 is a timer tick carrying the raw
// buttons (bit0 right, bit1 center, bit2 left); s_func 1 ends a sync
// measurement window and carries the sync edge count.
// m_ channel: exactly one result word per input word, in order. Every
// UPDATE_PERIOD-th tick raises m_update_strobe with the enable and LED
// words; otherwise both words are zero.
// cfg_ channel: register writes (0 input count, 1 sync threshold,
// 2 lost window limit), always ready; write only while the block is idle.
// The result word is registered: an accepted word goes to the input register,
// then to the result register. Throughput: one word per cycle while m_ready
// is high, set by the single state update step between those registers.
// When m_ready is low the result register holds and the input register
// still takes one more word; s_ready then drops until the result leaves.
// Reset (aresetn low, synchronous): no pending words, default register
// values, input 0 selected and marked lost, LEDs on, auto mode off.
`timescale 1ns / 1ps
`default_nettype none

module video_input_autoselect_core
    import vias_pkg::*;
#(
    parameter int DEBOUNCE_DEPTH = 8,
    parameter int UPDATE_PERIOD  = 32,
    parameter int HISTORY_DEPTH  = 4,
    parameter int MAX_INPUTS     = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [2:0]  s_raw_buttons,
    input  wire logic [7:0]  s_sync_count,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_selected_input,
    output logic             m_sync_lost,
    output logic             m_auto_mode,
    output logic             m_input_leds_on,
    output logic [23:0]      m_enable_word,
    output logic [23:0]      m_led_word,
    output logic             m_update_strobe,
    output logic             m_sample_ready,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int PW = (DEBOUNCE_DEPTH > 1) ? $clog2(DEBOUNCE_DEPTH) : 1;
    localparam int TW = (UPDATE_PERIOD > 1) ? $clog2(UPDATE_PERIOD) : 1;
    localparam logic [PW-1:0] POS_LAST   = PW'(DEBOUNCE_DEPTH - 1);
    localparam logic [TW-1:0] PHASE_LAST = TW'(UPDATE_PERIOD - 1);

    logic [4:0]    input_count_reg;
    logic [7:0]    sync_threshold_reg;
    logic [7:0]    lost_limit_reg;

    logic          in_valid_reg;
    logic          in_func_reg;
    logic [2:0]    in_buttons_reg;
    logic [7:0]    in_sync_reg;

    logic [2:0]    ring_reg [DEBOUNCE_DEPTH];
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [TW-1:0] phase_reg;
    logic [TW-1:0] phase_next;
    logic [4:0]    hist_reg [HISTORY_DEPTH];
    logic [4:0]    hist_next [HISTORY_DEPTH];
    sel_state_t    st_reg;
    sel_state_t    st_next;
    sel_state_t    win_st;

    logic          advance;
    logic          is_tick;
    logic          update_tick;
    logic [2:0]    debounced;
    logic [31:0]   now_mask;
    logic [31:0]   old_mask;
    logic [23:0]   enable_next;
    logic [23:0]   led_next;

    assign cfg_ready = 1'b1;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign is_tick = (in_func_reg == FUNC_TICK);

    always_comb begin
        debounced = 3'b111;
        for (int i = 0; i < DEBOUNCE_DEPTH; i++) begin
            debounced = debounced & ring_reg[i];
        end
    end

    vias_window #(
        .MAX_INPUTS(MAX_INPUTS)
    ) u_window (
        .st_i             (st_reg),
        .buttons_i        (debounced),
        .sync_count_i     (in_sync_reg),
        .input_count_i    (input_count_reg),
        .sync_threshold_i (sync_threshold_reg),
        .lost_limit_i     (lost_limit_reg),
        .st_o             (win_st)
    );

    assign pos_next    = (pos_reg == POS_LAST) ? '0 : pos_reg + PW'(1);
    assign phase_next  = (phase_reg == PHASE_LAST) ? '0 : phase_reg + TW'(1);
    assign update_tick = is_tick && (phase_next == '0);

    assign now_mask = mask_of(st_reg.choice);
    assign old_mask = mask_of(hist_reg[HISTORY_DEPTH-1]);

    always_comb begin
        st_next = st_reg;
        hist_next[0] = st_reg.choice;
        for (int i = 1; i < HISTORY_DEPTH; i++) begin
            hist_next[i] = hist_reg[i-1];
        end
        enable_next = 24'd0;
        led_next    = 24'd0;
        if (is_tick) begin
            if (update_tick) begin
                st_next.ready = (now_mask == old_mask);
                enable_next   = now_mask[23:0] | old_mask[23:0];
                led_next      = (st_reg.leds_on && !st_reg.lost) ? enable_next : 24'd0;
            end
        end else if (st_reg.ready) begin
            st_next = win_st;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_count_reg    <= INPUT_COUNT_RST;
            sync_threshold_reg <= SYNC_THRESHOLD_RST;
            lost_limit_reg     <= LOST_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_INPUT_COUNT:    input_count_reg    <= cfg_data[4:0];
                CFG_SYNC_THRESHOLD: sync_threshold_reg <= cfg_data;
                CFG_LOST_LIMIT:     lost_limit_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_func_reg    <= s_func;
            in_buttons_reg <= s_raw_buttons;
            in_sync_reg    <= s_sync_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEBOUNCE_DEPTH; i++) begin
                ring_reg[i] <= 3'd0;
            end
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                hist_reg[i] <= 5'd0;
            end
            pos_reg   <= '0;
            phase_reg <= '0;
            st_reg    <= '{choice: 5'd0, lost: 1'b1, lost_windows: 8'd0, active: 1'b0,
                           auto_mode: 1'b0, step_down: 1'b0, leds_on: 1'b1,
                           ready: 1'b0, held: BTN_NONE};
        end else if (advance) begin
            if (is_tick) begin
                pos_reg            <= pos_next;
                ring_reg[pos_next] <= in_buttons_reg;
                phase_reg          <= phase_next;
                if (update_tick) begin
                    hist_reg <= hist_next;
                end
            end
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_selected_input <= st_next.choice;
            m_sync_lost      <= st_next.lost;
            m_auto_mode      <= st_next.auto_mode;
            m_input_leds_on  <= st_next.leds_on;
            m_enable_word    <= enable_next;
            m_led_word       <= led_next;
            m_update_strobe  <= update_tick;
            m_sample_ready   <= st_next.ready;
        end
    end

endmodule

`default_nettype wire
